### rtl/core/bfpt_pkg.sv
// bfpt_pkg: shared types, codes and widths of the bidirectional flow permit table
// used by bfpt_cell and bidirectional_flow_permit_table; no dependencies
package bfpt_pkg;

  // sizing
  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int CMD_W             = 3;
  localparam int ADDR_W            = 32;
  localparam int PORT_W            = 16;
  localparam int PROTO_W           = 8;
  localparam int VERDICT_W         = 2;
  localparam int STATUS_W          = 2;
  localparam int IN_TDATA_W        = 104;
  localparam int OUT_TDATA_W       = 112;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_QUERY_V4    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY_V6    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CONN_REMOVE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MATCH_ADDR  = 3'd5;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_NOT_YET = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_PERMIT  = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_DENY    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUP      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_V4 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_V6 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd2;

  // direction-free flow key; field order gives the listing order as a plain compare
  typedef struct packed {
    logic [ADDR_W-1:0]  lo_addr;
    logic [PORT_W-1:0]  lo_port;
    logic [ADDR_W-1:0]  hi_addr;
    logic [PORT_W-1:0]  hi_port;
    logic [PROTO_W-1:0] proto;
  } flow_key_t;

  // commands broadcast from the controller to every cell
  typedef struct packed {
    logic insert;
    logic erase;
    logic rotate;
  } cell_ctrl_t;

endpackage

### rtl/core/bfpt_cell.sv
// bfpt_cell: one slot of the flow table, holding a valid bit and one flow key
// depends on bfpt_pkg; chained by bidirectional_flow_permit_table
module bfpt_cell import bfpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl_i,
  input  flow_key_t  key_i,       // broadcast lookup / insert key
  input  logic       nb_valid_i,  // neighbour contents, taken on rotate
  input  flow_key_t  nb_key_i,
  input  logic       take_i,      // a lower slot already takes the insert
  output logic       take_o,
  output logic       valid_o,
  output flow_key_t  key_o,
  output logic       hit_o
);

  logic      valid_r, valid_nxt;
  flow_key_t key_r, key_nxt;
  logic      claim;

  // key compare and free-slot chain
  assign hit_o  = valid_r && (key_r == key_i);
  assign take_o = take_i | ~valid_r;
  assign claim  = ctrl_i.insert && !take_i && !valid_r;

  // slot update
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (ctrl_i.rotate) begin
      valid_nxt = nb_valid_i;
      key_nxt   = nb_key_i;
    end else if (claim) begin
      valid_nxt = 1'b1;
      key_nxt   = key_i;
    end else if (ctrl_i.erase && hit_o) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // key storage needs no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign valid_o = valid_r;
  assign key_o   = key_r;

endmodule

### rtl/core/bidirectional_flow_permit_table.sv
// bidirectional_flow_permit_table: top level, command control and a ring of flow cells
// depends on bfpt_pkg and bfpt_cell
//
// Usage: commands arrive as words on the in_ stream (command in in_tuser, the flow in
// in_tdata); results leave as words on the out_ stream, the final word of each command
// marked by out_tlast. Configuration is written through cfg_we / cfg_index / cfg_wdata
// while the block is idle.
// Query, insert, erase and connection removal: one word is taken, the key is compared
// against every cell at once in the following cycle, and the result word is registered
// once the output register is free. No new command word is taken until then.
// Match by address: the cell ring is rotated once through the head cell per round,
// followed by a closing state; each round finds the next larger matching key, and a
// round that finds none ends the command.
// The output register frees the input side: a new command word is taken while a result
// waits. When the receiver stalls, the word on out_tdata holds and the block waits at its
// result stage.
// Reset empties the table (valid bits only) and clears all configuration to zero.
module bidirectional_flow_permit_table import bfpt_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // command stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // src_addr[31:0], sport[47:32], proto[55:48], dst_addr[87:56], dport[103:88]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command[2:0]
  input  logic [CMD_W-1:0]       in_tuser,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // verdict[1:0], status[3:2], found[4], ent_lo_addr[36:5], ent_lo_port[52:37],
  // ent_hi_addr[84:53], ent_hi_port[100:85], ent_proto[108:101], zero[111:109]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // controller states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_RDONE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  flow_key_t          key_r, key_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  flow_key_t          best_r, best_nxt;
  logic               best_ok_r, best_ok_nxt;
  flow_key_t          prev_r, prev_nxt;
  logic               prev_ok_r, prev_ok_nxt;

  logic               force_v4_r, force_v6_r, enable_r;

  logic               out_valid_r, out_valid_nxt;
  logic [VERDICT_W-1:0] out_verdict_r, out_verdict_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic               out_found_r, out_found_nxt;
  flow_key_t          out_ent_r, out_ent_nxt;
  logic               out_last_r, out_last_nxt;

  cell_ctrl_t         ctrl;
  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [TABLE_ENTRIES:0]   take_vec;
  flow_key_t          key_arr [TABLE_ENTRIES];

  logic               any_hit, table_full, out_free;

  // incoming flow fields
  logic [ADDR_W-1:0]  in_src_addr, in_dst_addr;
  logic [PORT_W-1:0]  in_sport, in_dport;
  logic [PROTO_W-1:0] in_proto;

  assign in_src_addr = in_tdata[31:0];
  assign in_sport    = in_tdata[47:32];
  assign in_proto    = in_tdata[55:48];
  assign in_dst_addr = in_tdata[87:56];
  assign in_dport    = in_tdata[103:88];

  // ring of cells, each taking its upper neighbour on rotate
  assign take_vec[0] = 1'b0;
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    localparam int NB = (g + 1) % TABLE_ENTRIES;
    bfpt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (ctrl),
      .key_i      (key_r),
      .nb_valid_i (valid_vec[NB]),
      .nb_key_i   (key_arr[NB]),
      .take_i     (take_vec[g]),
      .take_o     (take_vec[g+1]),
      .valid_o    (valid_vec[g]),
      .key_o      (key_arr[g]),
      .hit_o      (hit_vec[g])
    );
  end

  assign any_hit    = |hit_vec;
  assign table_full = ~take_vec[TABLE_ENTRIES];
  assign out_free   = ~out_valid_r | out_tready;
  assign in_tready  = (state_r == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_v4_r <= 1'b0;
      force_v6_r <= 1'b0;
      enable_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORCE_V4: force_v4_r <= cfg_wdata[0];
        CFG_FORCE_V6: force_v6_r <= cfg_wdata[0];
        CFG_ENABLE:   enable_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // command sequencer
  always_comb begin
    logic      emit;
    logic      head_match, head_above, head_below;
    flow_key_t head;

    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    key_nxt         = key_r;
    addr_nxt        = addr_r;
    cnt_nxt         = cnt_r;
    best_nxt        = best_r;
    best_ok_nxt     = best_ok_r;
    prev_nxt        = prev_r;
    prev_ok_nxt     = prev_ok_r;
    ctrl            = '0;
    emit            = 1'b0;
    out_verdict_nxt = VERDICT_NOT_YET;
    out_status_nxt  = STATUS_OK;
    out_found_nxt   = 1'b0;
    out_ent_nxt     = '0;
    out_last_nxt    = 1'b1;
    head            = key_arr[0];
    head_match      = valid_vec[0] && (head.lo_addr == addr_r || head.hi_addr == addr_r);
    head_above      = !prev_ok_r || (head > prev_r);
    head_below      = !best_ok_r || (head < best_r);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt  = in_tuser;
          addr_nxt = in_src_addr;
          key_nxt.proto = in_proto;
          if (in_src_addr < in_dst_addr) begin
            key_nxt.lo_addr = in_src_addr;
            key_nxt.lo_port = in_sport;
            key_nxt.hi_addr = in_dst_addr;
            key_nxt.hi_port = in_dport;
          end else begin
            key_nxt.lo_addr = in_dst_addr;
            key_nxt.lo_port = in_dport;
            key_nxt.hi_addr = in_src_addr;
            key_nxt.hi_port = in_sport;
          end
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          emit      = 1'b1;
          case (cmd_r)
            CMD_QUERY_V4: begin
              out_verdict_nxt = (force_v4_r || any_hit) ? VERDICT_PERMIT : VERDICT_NOT_YET;
              out_found_nxt   = any_hit;
            end
            CMD_QUERY_V6: begin
              out_verdict_nxt = force_v6_r ? VERDICT_PERMIT : VERDICT_DENY;
            end
            CMD_INSERT: begin
              if (!enable_r) begin
                out_status_nxt = STATUS_REJECTED;
              end else if (any_hit) begin
                out_status_nxt = STATUS_DUP;
                out_found_nxt  = 1'b1;
              end else if (table_full) begin
                out_status_nxt = STATUS_FULL;
              end else begin
                ctrl.insert = 1'b1;
              end
            end
            CMD_ERASE, CMD_CONN_REMOVE: begin
              if (cmd_r == CMD_ERASE && !enable_r) begin
                out_status_nxt = STATUS_REJECTED;
              end else begin
                ctrl.erase    = 1'b1;
                out_found_nxt = any_hit;
              end
            end
            CMD_MATCH_ADDR: begin
              if (!enable_r) begin
                out_status_nxt = STATUS_REJECTED;
              end else begin
                emit        = 1'b0;
                state_nxt   = S_SCAN;
                cnt_nxt     = '0;
                best_ok_nxt = 1'b0;
                prev_ok_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // one full turn of the ring past the head cell
        ctrl.rotate = 1'b1;
        if (head_match && head_above && head_below) begin
          best_nxt    = head;
          best_ok_nxt = 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_RDONE;
        end
      end
      S_RDONE: begin
        // the held entry goes out once it is known whether another follows
        if (out_free) begin
          if (best_ok_r) begin
            emit          = prev_ok_r;
            out_found_nxt = 1'b1;
            out_ent_nxt   = prev_r;
            out_last_nxt  = 1'b0;
            prev_nxt      = best_r;
            prev_ok_nxt   = 1'b1;
            best_ok_nxt   = 1'b0;
            cnt_nxt       = '0;
            state_nxt     = S_SCAN;
          end else begin
            emit          = 1'b1;
            out_found_nxt = prev_ok_r;
            out_ent_nxt   = prev_ok_r ? prev_r : '0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = emit | (out_valid_r & ~out_tready);
    if (!emit) begin
      out_verdict_nxt = out_verdict_r;
      out_status_nxt  = out_status_r;
      out_found_nxt   = out_found_r;
      out_ent_nxt     = out_ent_r;
      out_last_nxt    = out_last_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      best_ok_r   <= 1'b0;
      prev_ok_r   <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      best_ok_r   <= best_ok_nxt;
      prev_ok_r   <= prev_ok_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    addr_r        <= addr_nxt;
    best_r        <= best_nxt;
    prev_r        <= prev_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_status_r  <= out_status_nxt;
    out_found_r   <= out_found_nxt;
    out_ent_r     <= out_ent_nxt;
    out_last_r    <= out_last_nxt;
  end

  // result word
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_ent_r.proto, out_ent_r.hi_port, out_ent_r.hi_addr,
                       out_ent_r.lo_port, out_ent_r.lo_addr, out_found_r,
                       out_status_r, out_verdict_r};

  // an insert fills exactly one slot
  a_insert_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.insert |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("insert did not fill exactly one slot");

  // an erase of a present key frees exactly one slot
  a_erase_frees_one: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.erase && any_hit) |=> $countones(valid_vec) == $past($countones(valid_vec)) - 1)
    else $error("erase did not free exactly one slot");

  // rotation keeps the table contents
  a_rotate_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rotate |=> $countones(valid_vec) == $past($countones(valid_vec)))
    else $error("rotation changed the number of stored flows");

  // no table update while a result cannot be placed
  a_update_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.insert || ctrl.erase) |-> out_free)
    else $error("table updated while the output register was blocked");

  // listed entries rise strictly from round to round
  a_listing_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDONE && best_ok_r && prev_ok_r) |-> (best_r > prev_r))
    else $error("match listing out of key order");

endmodule
